// File: hw/rtl/acfb_pkg.sv
// acfb_pkg: shared types, constants and AES helper functions for the CFB block unit
// no dependencies
package acfb_pkg;

    localparam int unsigned ROUNDS = 10;

    typedef enum logic [1:0] {
        REG_KEY_UPPER = 2'd0,
        REG_KEY_LOWER = 2'd1,
        REG_IV_UPPER  = 2'd2,
        REG_IV_LOWER  = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [63:0] data_upper;
        logic [63:0] data_lower;
        logic        opcode;
        logic        last_block;
    } in_word_t;

    typedef struct packed {
        logic [63:0] result_upper;
        logic [63:0] result_lower;
        logic        last_out;
    } out_word_t;

    typedef struct packed {
        logic         start;
        logic [127:0] block;
        logic [127:0] key;
    } core_cmd_t;

    typedef struct packed {
        logic         busy;
        logic         done;
        logic [127:0] block;
    } core_sts_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block sits at bits 127-8i
    function automatic logic [7:0] byte_at(input logic [127:0] b, input int i);
        return b[127 - 8 * i -: 8];
    endfunction

    function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                    input logic [7:0] rcon);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {sbox(w3[23:16]) ^ rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic logic [127:0] cipher_round(input logic [127:0] s,
                                                  input logic mix);
        logic [127:0] t, m;
        logic [7:0]   a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[127 - 8 * (c * 4 + i) -: 8] = sbox(byte_at(s, ((c + i) % 4) * 4 + i));
            end
        end
        m = t;
        for (int c = 0; c < 4; c++) begin
            a0 = byte_at(t, c * 4);
            a1 = byte_at(t, c * 4 + 1);
            a2 = byte_at(t, c * 4 + 2);
            a3 = byte_at(t, c * 4 + 3);
            al = a0 ^ a1 ^ a2 ^ a3;
            m[127 - 8 * (c * 4) -: 8]     = a0 ^ al ^ xtime(a0 ^ a1);
            m[127 - 8 * (c * 4 + 1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            m[127 - 8 * (c * 4 + 2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            m[127 - 8 * (c * 4 + 3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return mix ? m : t;
    endfunction

endpackage

// File: hw/rtl/acfb_core.sv
// acfb_core: iterative AES-128 encryption, one round and one key step per cycle
// depends on acfb_pkg
module acfb_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  acfb_pkg::core_cmd_t cmd,
    output acfb_pkg::core_sts_t sts
);
    import acfb_pkg::*;

    logic [127:0] state_reg, state_next;
    logic [127:0] rkey_reg, rkey_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic [3:0]   round_reg, round_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;

    always_comb begin
        state_next = state_reg;
        rkey_next  = rkey_reg;
        rcon_next  = rcon_reg;
        round_next = round_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (cmd.start) begin
            state_next = cmd.block ^ cmd.key;
            rkey_next  = cmd.key;
            rcon_next  = 8'h01;
            round_next = 4'd1;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            rkey_next  = next_round_key(rkey_reg, rcon_reg);
            state_next = cipher_round(state_reg, round_reg != 4'(ROUNDS)) ^ rkey_next;
            rcon_next  = xtime(rcon_reg);
            round_next = round_reg + 4'd1;
            if (round_reg == 4'(ROUNDS)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            round_reg <= round_next;
        end
        state_reg <= state_next;
        rkey_reg  <= rkey_next;
        rcon_reg  <= rcon_next;
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign sts.block = state_reg;

endmodule

// File: hw/rtl/aes128_cfb_block_cipher.sv
// aes128_cfb_block_cipher: AES-128 CFB-128 block unit, one word in, one word out
// path: input registered, loaded, run through 10 rounds, xored into the output register
// one word at a time, set by the shared round unit and the feedback loop
// the next input is taken while a finished result still waits in the output register
// reset: synchronous active-low aresetn; key and iv clear to zero, next word uses the iv
// depends on acfb_pkg and acfb_core
module aes128_cfb_block_cipher (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  acfb_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output acfb_pkg::out_word_t m_data
);
    import acfb_pkg::*;

    // feedback memory: entry 0 upper half, entry 1 lower half, one write port
    logic [63:0] fb_mem [2];
    logic [127:0] fb_rd_reg;
    logic [63:0] key_u_reg, key_l_reg, iv_u_reg, iv_l_reg;
    logic        start_reg;
    logic        fill_reg;
    logic        load_reg;
    logic        wb_reg;
    logic [63:0] wb_lo_reg;
    in_word_t    item_reg;
    core_cmd_t   cmd;
    core_sts_t   sts;
    logic        busy_reg, busy_next;
    logic        pend_reg;
    logic        done_now;
    logic        out_valid_reg;
    out_word_t   out_reg;
    logic [127:0] res;

    // finished result moves to the output register once it is free
    assign done_now  = (sts.done || pend_reg) && !(out_valid_reg && !m_ready);
    assign s_ready   = !busy_reg;
    assign res       = {item_reg.data_upper, item_reg.data_lower} ^ sts.block;
    assign busy_next = busy_reg ? !done_now : (s_valid && s_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_u_reg <= '0;
            key_l_reg <= '0;
            iv_u_reg  <= '0;
            iv_l_reg  <= '0;
        end else if (cfg_we) begin
            case (reg_index_t'(cfg_index))
                REG_KEY_UPPER: key_u_reg <= cfg_data;
                REG_KEY_LOWER: key_l_reg <= cfg_data;
                REG_IV_UPPER:  iv_u_reg  <= cfg_data;
                REG_IV_LOWER:  iv_l_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // memory: both halves read at accept; upper written at done, lower later via wb_reg
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            fb_rd_reg <= {fb_mem[0], wb_reg ? wb_lo_reg : fb_mem[1]};
        end
        if (done_now) begin
            fb_mem[0] <= item_reg.opcode ? item_reg.data_upper : res[127:64];
        end else if (wb_reg) begin
            fb_mem[1] <= wb_lo_reg;
        end
        if (done_now) begin
            wb_lo_reg <= item_reg.opcode ? item_reg.data_lower : res[63:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            load_reg      <= 1'b0;
            wb_reg        <= 1'b0;
            fill_reg      <= 1'b1;
            start_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            pend_reg <= (sts.done || pend_reg) && !done_now;
            load_reg <= s_valid && s_ready;
            wb_reg   <= done_now;
            if (s_valid && s_ready) begin
                fill_reg <= start_reg;
            end
            if (done_now) begin
                start_reg <= item_reg.last_block;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        if (done_now) begin
            out_reg.result_upper <= res[127:64];
            out_reg.result_lower <= res[63:0];
            out_reg.last_out     <= item_reg.last_block;
        end
    end

    always_comb begin
        cmd.start = load_reg;
        cmd.block = fill_reg ? {iv_u_reg, iv_l_reg} : fb_rd_reg;
        cmd.key   = {key_u_reg, key_l_reg};
    end

    acfb_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
